FILE: hdl/krw_pkg.sv
// Shared types and constants for the keyframe replay window cache.
// No dependencies; all files but krw_ifs and krw_ram import it.
`default_nettype none

package krw_pkg;

	localparam int DEPTH_DEF = 1024;
	localparam int STREAMS = 16;
	localparam logic [15:0] STREAM_MASK = 16'hFFFF;
	// current position may run this far past the max stored position
	localparam logic signed [48:0] COVER_TOL = 49'sd2500000;

	typedef enum logic [1:0] {
		CMD_OBSERVE = 2'd0,
		CMD_QUERY   = 2'd1,
		CMD_CLEAR   = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		STS_OK       = 3'd0,
		STS_DISABLED = 3'd1,
		STS_EMPTY    = 3'd2,
		STS_OUTSIDE  = 3'd3,
		STS_NOKEY    = 3'd4,
		STS_COVER    = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		REG_ENABLE  = 3'd0,
		REG_MASK    = 3'd1,
		REG_VIDEO   = 3'd2,
		REG_MAX_PK  = 3'd3,
		REG_MAX_B   = 3'd4,
		REG_MAX_D   = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic        enabled;
		logic [15:0] mask;
		logic [3:0]  video;
		logic [10:0] max_pk;
		logic [39:0] max_b;
		logic [46:0] max_d;
	} cfg_t;

	typedef struct packed {
		logic [3:0]  stream;
		logic [46:0] pos;
		logic        key;
		logic [23:0] size;
	} slot_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRE,
		ST_WR,
		ST_LIM,
		ST_SCAN,
		ST_QEVAL,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		MD_DROP,
		MD_WIN,
		MD_Q1,
		MD_Q2
	} mode_t;

endpackage

`default_nettype wire

FILE: hdl/krw_ifs.sv
// Valid/ready channel interfaces for request and result items.
// Depends on nothing but plain logic types.
`default_nettype none

interface krw_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic [3:0]         stream_id;
	logic signed [47:0] packet_position;
	logic               key_flag;
	logic [23:0]        packet_size;
	logic signed [47:0] target_ticks;
	logic signed [47:0] current_ticks;

	modport source (output valid, cmd, stream_id, packet_position, key_flag, packet_size,
		target_ticks, current_ticks, input ready);
	modport sink (input valid, cmd, stream_id, packet_position, key_flag, packet_size,
		target_ticks, current_ticks, output ready);
endinterface

interface krw_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic        hit;
	logic [63:0] first_sequence;
	logic [10:0] replay_count;
	logic [39:0] replay_bytes;
	logic [46:0] replay_window;
	logic [10:0] stored_count;
	logic [39:0] stored_bytes;
	logic [46:0] stored_window;
	logic        enabled_echo;

	modport source (output valid, status, hit, first_sequence, replay_count, replay_bytes,
		replay_window, stored_count, stored_bytes, stored_window, enabled_echo, input ready);
	modport sink (input valid, status, hit, first_sequence, replay_count, replay_bytes,
		replay_window, stored_count, stored_bytes, stored_window, enabled_echo, output ready);
endinterface

`default_nettype wire

FILE: hdl/krw_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module krw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

`default_nettype wire

FILE: hdl/krw_regs.sv
// APB configuration registers; flags a store clear on a write that
// changes enable, mask or video, or disables. Depends on krw_pkg.
`default_nettype none

module krw_regs import krw_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready,
	output cfg_t             cfg,
	output logic             cfg_clr
);
	cfg_t     cfg_q;
	logic     wr;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign idx = reg_idx_t'(paddr[5:3]);
	assign cfg = cfg_q;

	always_comb begin
		cfg_clr = 1'b0;
		if (wr) begin
			case (idx)
				REG_ENABLE: cfg_clr = (pwdata[0] != cfg_q.enabled) || !pwdata[0];
				REG_MASK:   cfg_clr = pwdata[15:0] != cfg_q.mask;
				REG_VIDEO:  cfg_clr = pwdata[3:0] != cfg_q.video;
				default:    cfg_clr = 1'b0;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ENABLE: prdata = 64'(cfg_q.enabled);
			REG_MASK:   prdata = 64'(cfg_q.mask);
			REG_VIDEO:  prdata = 64'(cfg_q.video);
			REG_MAX_PK: prdata = 64'(cfg_q.max_pk);
			REG_MAX_B:  prdata = 64'(cfg_q.max_b);
			REG_MAX_D:  prdata = 64'(cfg_q.max_d);
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled <= 1'b0;
			cfg_q.mask    <= '0;
			cfg_q.video   <= '0;
			cfg_q.max_pk  <= 11'd1024;
			cfg_q.max_b   <= '1;
			cfg_q.max_d   <= '1;
		end else if (wr) begin
			case (idx)
				REG_ENABLE: cfg_q.enabled <= pwdata[0];
				REG_MASK:   cfg_q.mask    <= pwdata[15:0];
				REG_VIDEO:  cfg_q.video   <= pwdata[3:0];
				REG_MAX_PK: cfg_q.max_pk  <= pwdata[10:0];
				REG_MAX_B:  cfg_q.max_b   <= pwdata[39:0];
				REG_MAX_D:  cfg_q.max_d   <= pwdata[46:0];
				default:    ;
			endcase
		end
	end
endmodule

`default_nettype wire

FILE: hdl/krw_ctrl.sv
// Sequencer that scans, prunes and queries the descriptor ring in memory.
// Depends on krw_pkg, krw_ifs and krw_ram.
`default_nettype none

module krw_ctrl import krw_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic cfg_clr,
	krw_req_if.sink   req,
	krw_rsp_if.source rsp
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [CW-1:0] off);
		logic [CW:0] s;
		s = (CW+1)'(base) + (CW+1)'(off);
		if (s >= (CW+1)'(DEPTH)) begin
			s = s - (CW+1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	state_t state_q, state_d;
	mode_t  mode_q;
	logic   phase_q;

	logic [3:0]         sid_q;
	logic [47:0]        pos_q;
	logic               key_q;
	logic [23:0]        size_q;
	logic signed [47:0] tgt_q;
	logic signed [47:0] cur_q;

	logic [AW-1:0] head_q;
	logic [CW-1:0] cnt_q;
	logic [39:0]   bytes_q;
	logic [63:0]   seq_q;
	logic [46:0]   win_q;

	logic [CW-1:0] iss_q, end_q, idx_s1, start_q;
	logic          vld_s1, found_q;
	logic [39:0]   acc_q;
	logic [46:0]   lo_q, hi_q, spos_q;
	logic [15:0]   cov_q;

	status_t     r_status_q;
	logic        r_hit_q;
	logic [63:0] r_first_q;
	logic [10:0] r_count_q;
	logic [39:0] r_bytes_q;
	logic [46:0] r_win_q;
	logic        out_vld_q;

	logic        issue, scan_end, drop_key, store_ok, over_cb, q_out, q_cur_bad, q_pass;
	logic [46:0] span;
	logic signed [48:0] hi_tol;
	slot_t       rdat, wdat;

	krw_ram #(.WIDTH($bits(slot_t)), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (state_q == ST_WR),
		.waddr (wrap(head_q, cnt_q)),
		.wdata (wdat),
		.re    (issue),
		.raddr (wrap(head_q, iss_q)),
		.rdata (rdat)
	);

	assign wdat.stream = sid_q;
	assign wdat.pos    = pos_q[46:0];
	assign wdat.key    = (sid_q == cfg.video) && key_q;
	assign wdat.size   = size_q;

	assign issue    = (state_q == ST_SCAN) && (iss_q < end_q);
	assign scan_end = (state_q == ST_SCAN) && (iss_q == end_q) && !vld_s1;
	assign drop_key = (state_q == ST_SCAN) && (mode_q == MD_DROP) && vld_s1
		&& (idx_s1 != '0) && rdat.key;
	assign span     = hi_q - lo_q;
	assign store_ok = cfg.enabled && !req.packet_position[47]
		&& (32'(req.stream_id) < STREAMS) && cfg.mask[req.stream_id];
	assign over_cb  = (32'(cnt_q) > 32'(cfg.max_pk)) || (bytes_q > cfg.max_b);
	assign hi_tol   = $signed({2'b00, hi_q}) + COVER_TOL;
	assign q_out    = (tgt_q < $signed({1'b0, lo_q})) || (tgt_q > $signed({1'b0, hi_q}));
	assign q_cur_bad = (cur_q < tgt_q) || ($signed({cur_q[47], cur_q}) > hi_tol);
	assign q_pass   = !q_out && found_q && !q_cur_bad;

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = out_vld_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					case (cmd_t'(req.cmd))
						CMD_OBSERVE: state_d = store_ok ? ST_PRE : ST_FIN;
						CMD_QUERY:   state_d = (!cfg.enabled || cnt_q == '0) ? ST_FIN : ST_SCAN;
						default:     state_d = ST_FIN;
					endcase
				end
			end
			ST_PRE:   state_d = (cnt_q >= CW'(DEPTH)) ? ST_SCAN : ST_WR;
			ST_WR:    state_d = ST_LIM;
			ST_LIM:   state_d = (cnt_q == '0) ? ST_FIN : ST_SCAN;
			ST_SCAN: begin
				case (mode_q)
					MD_DROP: begin
						if (drop_key || scan_end) begin
							state_d = phase_q ? ST_LIM : ST_PRE;
						end
					end
					MD_WIN: begin
						if (scan_end) begin
							state_d = (span > cfg.max_d) ? ST_SCAN : ST_FIN;
						end
					end
					MD_Q1:   if (scan_end) state_d = ST_QEVAL;
					default: if (scan_end) state_d = ST_FIN;
				endcase
			end
			ST_QEVAL: state_d = q_pass ? ST_SCAN : ST_FIN;
			ST_FIN:   if (!out_vld_q || rsp.ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MD_DROP;
			phase_q   <= 1'b0;
			head_q    <= '0;
			cnt_q     <= '0;
			bytes_q   <= '0;
			seq_q     <= '0;
			win_q     <= '0;
			iss_q     <= '0;
			end_q     <= '0;
			idx_s1    <= '0;
			vld_s1    <= 1'b0;
			found_q   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			vld_s1 <= issue;
			idx_s1 <= iss_q;
			if (issue) begin
				iss_q <= iss_q + 1'b1;
			end
			if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						sid_q      <= req.stream_id;
						pos_q      <= req.packet_position;
						key_q      <= req.key_flag;
						size_q     <= req.packet_size;
						tgt_q      <= req.target_ticks;
						cur_q      <= req.current_ticks;
						phase_q    <= 1'b0;
						r_status_q <= STS_OK;
						r_hit_q    <= 1'b0;
						r_first_q  <= '0;
						r_count_q  <= '0;
						r_bytes_q  <= '0;
						r_win_q    <= '0;
						case (cmd_t'(req.cmd))
							CMD_QUERY: begin
								if (!cfg.enabled) begin
									r_status_q <= STS_DISABLED;
								end else if (cnt_q == '0) begin
									r_status_q <= STS_EMPTY;
								end else begin
									mode_q  <= MD_Q1;
									iss_q   <= '0;
									end_q   <= cnt_q;
									found_q <= 1'b0;
								end
							end
							CMD_CLEAR: begin
								cnt_q   <= '0;
								bytes_q <= '0;
								win_q   <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_PRE: begin
					if (cnt_q >= CW'(DEPTH)) begin
						mode_q <= MD_DROP;
						iss_q  <= '0;
						end_q  <= cnt_q;
						acc_q  <= '0;
					end
				end
				ST_WR: begin
					cnt_q   <= cnt_q + 1'b1;
					bytes_q <= bytes_q + 40'(size_q);
					seq_q   <= seq_q + 64'd1;
					phase_q <= 1'b1;
				end
				ST_LIM: begin
					iss_q <= '0;
					end_q <= cnt_q;
					acc_q <= '0;
					if (cnt_q == '0) begin
						win_q <= '0;
					end else if (over_cb) begin
						mode_q <= MD_DROP;
					end else begin
						mode_q <= MD_WIN;
					end
				end
				ST_SCAN: begin
					case (mode_q)
						MD_DROP: begin
							if (drop_key) begin
								head_q  <= wrap(head_q, idx_s1);
								cnt_q   <= cnt_q - idx_s1;
								bytes_q <= (bytes_q > acc_q) ? bytes_q - acc_q : '0;
							end else if (vld_s1) begin
								acc_q <= acc_q + 40'(rdat.size);
							end else if (scan_end) begin
								// no keyframe behind the front entry: empty the store
								cnt_q   <= '0;
								bytes_q <= '0;
							end
						end
						MD_WIN: begin
							if (vld_s1) begin
								if (idx_s1 == '0 || rdat.pos < lo_q) lo_q <= rdat.pos;
								if (idx_s1 == '0 || rdat.pos > hi_q) hi_q <= rdat.pos;
							end
							if (scan_end) begin
								if (span > cfg.max_d) begin
									mode_q <= MD_DROP;
									iss_q  <= '0;
									acc_q  <= '0;
								end else begin
									win_q <= span;
								end
							end
						end
						MD_Q1: begin
							if (vld_s1) begin
								if (idx_s1 == '0 || rdat.pos < lo_q) lo_q <= rdat.pos;
								if (idx_s1 == '0 || rdat.pos > hi_q) hi_q <= rdat.pos;
								if (rdat.key && ($signed({1'b0, rdat.pos}) <= tgt_q)) begin
									start_q <= idx_s1;
									found_q <= 1'b1;
									spos_q  <= rdat.pos;
								end
							end
						end
						default: begin
							if (vld_s1) begin
								acc_q <= acc_q + 40'(rdat.size);
								cov_q <= cov_q | (16'd1 << rdat.stream);
							end
							if (scan_end) begin
								if ((cfg.mask & STREAM_MASK & ~cov_q) != '0) begin
									r_status_q <= STS_COVER;
								end else begin
									r_hit_q   <= 1'b1;
									r_first_q <= seq_q - 64'(cnt_q) + 64'(start_q);
									r_count_q <= 11'(cnt_q - start_q);
									r_bytes_q <= acc_q;
									r_win_q   <= (hi_q > spos_q) ? hi_q - spos_q : '0;
								end
							end
						end
					endcase
				end
				ST_QEVAL: begin
					if (q_out) begin
						r_status_q <= STS_OUTSIDE;
					end else if (!found_q) begin
						r_status_q <= STS_NOKEY;
					end else if (q_cur_bad) begin
						r_status_q <= STS_COVER;
					end else begin
						mode_q <= MD_Q2;
						iss_q  <= start_q;
						end_q  <= cnt_q;
						acc_q  <= '0;
						cov_q  <= '0;
					end
				end
				ST_FIN: begin
					if (!out_vld_q || rsp.ready) begin
						out_vld_q          <= 1'b1;
						rsp.status         <= r_status_q;
						rsp.hit            <= r_hit_q;
						rsp.first_sequence <= r_first_q;
						rsp.replay_count   <= r_count_q;
						rsp.replay_bytes   <= r_bytes_q;
						rsp.replay_window  <= r_win_q;
						rsp.stored_count   <= 11'(cnt_q);
						rsp.stored_bytes   <= bytes_q;
						rsp.stored_window  <= win_q;
						rsp.enabled_echo   <= cfg.enabled;
					end
				end
				default: ;
			endcase
			if (cfg_clr) begin
				cnt_q   <= '0;
				bytes_q <= '0;
				win_q   <= '0;
			end
		end
	end
endmodule

`default_nettype wire

FILE: hdl/keyframe_replay_window_cache.sv
// Keyframe replay window cache: a ring of packet descriptors held in one
// synchronous RAM, walked by a sequencer one entry per cycle. An item is taken
// only while the sequencer is idle. Clear and rejected observes go straight to
// the result; a stored observe writes the entry, then takes a limit step and a
// window check over the held entries, plus, for each group dropped, one pass
// over the front group, a limit step and a new window check. A query makes one
// pass over all entries for span and keyframe and one from the replay start for
// bytes and stream coverage. All passes share the single RAM read port.
// The result sits in an output register, so the next item is taken while it waits.
`default_nettype none

module keyframe_replay_window_cache import krw_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready,
	krw_req_if.sink          req,
	krw_rsp_if.source        rsp
);
	cfg_t cfg;
	logic cfg_clr;

	krw_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.cfg_clr (cfg_clr)
	);

	krw_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_clr (cfg_clr),
		.req     (req),
		.rsp     (rsp)
	);
endmodule

`default_nettype wire

FILE: tb/sv/keyframe_replay_window_cache_tb.sv
// Self-checking testbench for keyframe_replay_window_cache: directed and random
// packet/query traffic on valid/ready channels, APB register setup, cycle-free predictor.
// Depends on krw_pkg, krw_ifs and the keyframe_replay_window_cache RTL.
`timescale 1ns / 100ps

module keyframe_replay_window_cache_tb;
	import krw_pkg::*;

	localparam int RING = 1024;
	localparam longint TOL = 64'd2500000;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int REG_UNUSED = 7;
	localparam logic [39:0] BYTES_MAX = 40'hFF_FFFF_FFFF;
	localparam logic [46:0] DUR_MAX = 47'h7FFF_FFFF_FFFF;

	typedef struct {
		cmd_t               cmd;
		logic [3:0]         sid;
		logic signed [47:0] pos;
		logic               key;
		logic [23:0]        size;
		logic signed [47:0] tgt;
		logic signed [47:0] cur;
	} pkt_req_t;

	typedef struct {
		logic [2:0]  status;
		logic        hit;
		logic [63:0] first_seq;
		logic [10:0] rcount;
		logic [39:0] rbytes;
		logic [46:0] rwin;
		logic [10:0] scount;
		logic [39:0] sbytes;
		logic [46:0] swin;
		logic        en;
	} cache_result_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [5:0] paddr;
	logic [63:0] pwdata, prdata;

	krw_req_if req ();
	krw_rsp_if rsp ();

	keyframe_replay_window_cache dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req(req.sink), .rsp(rsp.source)
	);

	// mirror of the cache contents and registers
	logic [3:0]  ring_stream [RING];
	longint      ring_pos [RING];
	logic        ring_key [RING];
	logic [23:0] ring_size [RING];
	int          head, count;
	logic [39:0] bytes_held;
	logic [63:0] seq_next;
	cfg_t        cfg;

	cache_result_t pending_results[$];
	int errors = 0;
	int snd_idle_pct = 0, rcv_idle_pct = 0;
	longint pos_cursor = 0;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int ring_at(int i);
		return (head + i) % RING;
	endfunction

	function automatic void held_span(output longint lo, output longint hi);
		lo = 0;
		hi = 0;
		for (int i = 0; i < count; i++) begin
			if (i == 0 || ring_pos[ring_at(i)] < lo) lo = ring_pos[ring_at(i)];
			if (i == 0 || ring_pos[ring_at(i)] > hi) hi = ring_pos[ring_at(i)];
		end
	endfunction

	function automatic longint held_window();
		longint lo, hi;
		held_span(lo, hi);
		return hi - lo;
	endfunction

	function automatic void empty_store();
		count = 0;
		bytes_held = '0;
	endfunction

	// drop the front entry and everything up to the next keyframe
	function automatic void drop_group();
		int k;
		k = 1;
		while (k < count && !ring_key[ring_at(k)]) k++;
		if (k >= count) begin
			empty_store();
			return;
		end
		for (int j = 0; j < k; j++)
			bytes_held = (bytes_held > ring_size[ring_at(j)]) ?
				bytes_held - 40'(ring_size[ring_at(j)]) : '0;
		head = ring_at(k);
		count -= k;
	endfunction

	function automatic bit over_limit();
		return count > cfg.max_pk || bytes_held > cfg.max_b || held_window() > cfg.max_d;
	endfunction

	function automatic void store_packet(pkt_req_t r);
		int s;
		if (!cfg.enabled || r.pos < 0 || !cfg.mask[r.sid]) return;
		while (count >= RING) drop_group();
		s = ring_at(count);
		ring_stream[s] = r.sid;
		ring_pos[s] = longint'(r.pos);
		ring_key[s] = (r.sid == cfg.video) && r.key;
		ring_size[s] = r.size;
		count++;
		bytes_held = bytes_held + 40'(r.size);
		seq_next++;
		while (count > 0 && over_limit()) drop_group();
	endfunction

	function automatic logic [2:0] replay_lookup(pkt_req_t r, inout cache_result_t res);
		longint lo, hi, tgt, cur;
		logic [15:0] covered;
		logic [39:0] sum;
		int start;
		bit found;
		tgt = longint'(r.tgt);
		cur = longint'(r.cur);
		covered = '0;
		sum = '0;
		start = 0;
		found = 0;
		if (!cfg.enabled) return STS_DISABLED;
		if (count == 0) return STS_EMPTY;
		held_span(lo, hi);
		if (tgt < lo || tgt > hi) return STS_OUTSIDE;
		for (int i = 0; i < count; i++)
			if (ring_key[ring_at(i)] && ring_pos[ring_at(i)] <= tgt) begin
				start = i;
				found = 1;
			end
		if (!found) return STS_NOKEY;
		if (cur < tgt || cur > hi + TOL) return STS_COVER;
		for (int i = start; i < count; i++) begin
			covered[ring_stream[ring_at(i)]] = 1'b1;
			sum += 40'(ring_size[ring_at(i)]);
		end
		if ((cfg.mask & ~covered) != 0) return STS_COVER;
		res.hit = 1'b1;
		res.first_seq = seq_next - 64'(count) + 64'(start);
		res.rcount = 11'(count - start);
		res.rbytes = sum;
		res.rwin = 47'(hi - ring_pos[ring_at(start)]);
		return STS_OK;
	endfunction

	function automatic cache_result_t cache_predict(pkt_req_t r);
		cache_result_t res;
		res = '{default: '0};
		case (r.cmd)
			CMD_OBSERVE: store_packet(r);
			CMD_QUERY: res.status = replay_lookup(r, res);
			CMD_CLEAR: empty_store();
			default: ;
		endcase
		res.scount = 11'(count);
		res.sbytes = bytes_held;
		res.swin = 47'(held_window());
		res.en = cfg.enabled;
		return res;
	endfunction

	task automatic send_item(pkt_req_t r);
		cache_result_t pred;
		if ($urandom_range(99) < snd_idle_pct) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= r.cmd;
		req.stream_id <= r.sid;
		req.packet_position <= r.pos;
		req.key_flag <= r.key;
		req.packet_size <= r.size;
		req.target_ticks <= r.tgt;
		req.current_ticks <= r.cur;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		pred = cache_predict(r);
		pending_results = {pending_results, pred};
	endtask

	task automatic send_observe(logic [3:0] sid, longint pos, logic key, logic [23:0] size);
		send_item('{CMD_OBSERVE, sid, pos[47:0], key, size, '0, '0});
	endtask

	task automatic send_query(longint tgt, longint cur);
		send_item('{CMD_QUERY, 4'($urandom), 48'({$urandom, $urandom}), 1'($urandom),
			24'($urandom), tgt[47:0], cur[47:0]});
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(int idx, logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 6'(idx * 8);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_ENABLE: begin
				if (value[0] != cfg.enabled || !value[0]) empty_store();
				cfg.enabled = value[0];
			end
			REG_MASK: begin
				if (value[15:0] != cfg.mask) empty_store();
				cfg.mask = value[15:0];
			end
			REG_VIDEO: begin
				if (value[3:0] != cfg.video) empty_store();
				cfg.video = value[3:0];
			end
			REG_MAX_PK: cfg.max_pk = value[10:0];
			REG_MAX_B: cfg.max_b = value[39:0];
			REG_MAX_D: cfg.max_d = value[46:0];
			default: ;
		endcase
	endtask

	task automatic configure(logic [15:0] mask, logic [3:0] video, logic [10:0] max_pk,
			logic [39:0] max_b, logic [46:0] max_d);
		drain();
		write_reg(REG_ENABLE, 64'd1);
		write_reg(REG_MASK, 64'(mask));
		write_reg(REG_VIDEO, 64'(video));
		write_reg(REG_MAX_PK, 64'(max_pk));
		write_reg(REG_MAX_B, 64'(max_b));
		write_reg(REG_MAX_D, 64'(max_d));
	endtask

	// response checker
	function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		cache_result_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
			end else begin
				e = pending_results.pop_front();
				check_field("status", e.status, rsp.status);
				check_field("hit", e.hit, rsp.hit);
				check_field("first_sequence", e.first_seq, rsp.first_sequence);
				check_field("replay_count", e.rcount, rsp.replay_count);
				check_field("replay_bytes", e.rbytes, rsp.replay_bytes);
				check_field("replay_window", e.rwin, rsp.replay_window);
				check_field("stored_count", e.scount, rsp.stored_count);
				check_field("stored_bytes", e.sbytes, rsp.stored_bytes);
				check_field("stored_window", e.swin, rsp.stored_window);
				check_field("enabled_echo", e.en, rsp.enabled_echo);
			end
		end
	end

	always @(posedge clk)
		rsp.ready <= ($urandom_range(99) >= rcv_idle_pct);

	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || psel || !arst_n)
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("keyframe_replay_window_cache_tb failed");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	task automatic test_disabled();
		send_observe(4'd0, 64'd10, 1'b1, 24'd5);
		send_query(64'd10, 64'd10);
		send_item('{CMD_CLEAR, '0, '0, '0, '0, '0, '0});
		send_item('{CMD_NOP, 4'hF, '1, 1'b1, '1, '1, '1});
	endtask

	task automatic test_basic_replay();
		configure(16'h0003, 4'd0, 11'd1024, BYTES_MAX, DUR_MAX);
		send_query(64'd0, 64'd0);                       // empty
		send_observe(4'd1, 64'd50, 1'b1, 24'd7);       // key flag off the video stream
		send_observe(4'd0, 64'd100, 1'b1, 24'd0);
		send_observe(4'd1, 64'd150, 1'b0, 24'hFFFFFF);
		send_observe(4'd2, 64'd160, 1'b1, 24'd9);      // inactive stream
		send_observe(4'd0, -64'd5, 1'b1, 24'd9);       // negative position
		send_query(64'd20, 64'd100);                    // before earliest
		send_query(64'd60, 64'd100);                    // no keyframe at or before
		send_query(64'd120, 64'd130);
		send_query(64'd120, 64'd110);                   // current behind target
		send_query(64'd120, 64'd150 + TOL);
		send_query(64'd120, 64'd151 + TOL);
		send_observe(4'd0, 64'h7FFF_FFFF_FFFF, 1'b0, 24'd3);
		send_query(64'h7FFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF);
		send_item('{CMD_NOP, '0, '0, '0, '0, '0, '0});
		send_item('{CMD_CLEAR, '0, '0, '0, '0, '0, '0});
		send_query(64'd100, 64'd100);
	endtask

	task automatic test_limits_and_config();
		drain();
		write_reg(REG_ENABLE, 64'd1);                   // same value, store kept
		write_reg(REG_MASK, 64'h0003);
		write_reg(REG_UNUSED, 64'hDEAD);
		send_observe(4'd0, 64'd10, 1'b1, 24'd100);
		send_observe(4'd1, 64'd20, 1'b0, 24'd100);
		drain();
		write_reg(REG_MAX_PK, 64'd0);
		send_observe(4'd0, 64'd30, 1'b1, 24'd1);
		drain();
		write_reg(REG_MAX_PK, 64'd1024);
		write_reg(REG_MAX_B, 64'd0);
		send_observe(4'd0, 64'd40, 1'b1, 24'd0);
		send_observe(4'd0, 64'd50, 1'b1, 24'd1);
		drain();
		write_reg(REG_MAX_B, 64'(BYTES_MAX));
		write_reg(REG_MAX_D, 64'd0);
		send_observe(4'd0, 64'd60, 1'b1, 24'd2);
		send_observe(4'd0, 64'd70, 1'b1, 24'd2);
		drain();
		write_reg(REG_ENABLE, 64'd0);
		write_reg(REG_MAX_D, 64'(DUR_MAX));
		write_reg(REG_VIDEO, 64'd15);
	endtask

	task automatic random_item();
		pkt_req_t r;
		longint lo, hi, span_w;
		int pick;
		pick = $urandom_range(99);
		r = '{CMD_OBSERVE, 4'($urandom), 48'({$urandom, $urandom}), 1'($urandom),
			24'($urandom), 48'({$urandom, $urandom}), 48'({$urandom, $urandom})};
		if (pick < 12) begin
			r.cmd = cmd_t'($urandom_range(3));          // noise
		end else if (pick < 70) begin
			pos_cursor += $urandom_range(0, 400000);
			r.pos = 48'(pos_cursor - $urandom_range(0, 3) * 50000);
			if ($urandom_range(3) != 0) r.sid = $urandom_range(3) == 0 ?
				cfg.video : 4'($urandom_range(15));
			r.key = ($urandom_range(4) == 0);
			if ($urandom_range(9) != 0) r.size = 24'($urandom_range(0, 30000));
		end else begin
			r.cmd = CMD_QUERY;
			held_span(lo, hi);
			span_w = hi - lo + 1;
			if (count > 0 && $urandom_range(9) != 0) begin
				r.tgt = 48'(lo + longint'({$urandom, $urandom} % span_w));
				r.cur = 48'(longint'(r.tgt) + $urandom_range(0, 5) * (span_w / 4 + TOL / 4)
					- ($urandom_range(9) == 0 ? 1 : 0));
			end
		end
		send_item(r);
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			if (i == n / 2) drain();
			random_item();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req.valid = 1'b0;
		req.cmd = CMD_OBSERVE;
		req.stream_id = '0;
		req.packet_position = '0;
		req.key_flag = 1'b0;
		req.packet_size = '0;
		req.target_ticks = '0;
		req.current_ticks = '0;
		rsp.ready = 1'b0;
		cfg = '{enabled: 1'b0, mask: '0, video: '0, max_pk: 11'd1024,
			max_b: BYTES_MAX, max_d: DUR_MAX};
		head = 0;
		count = 0;
		bytes_held = '0;
		seq_next = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_disabled();
		test_basic_replay();
		test_limits_and_config();

		snd_idle_pct = 28;
		rcv_idle_pct = 55;
		configure(16'h00F3, 4'd4, 11'd24, 40'd400000, 47'd3000000);
		test_random(90);
		snd_idle_pct = 55;
		rcv_idle_pct = 28;
		configure(16'hFFFF, 4'd15, 11'd1024, BYTES_MAX, 47'd20000000);
		test_random(86);
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		configure(16'h8001, 4'd0, 11'd60, BYTES_MAX, DUR_MAX);
		test_random(86);

		drain();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("keyframe_replay_window_cache_tb passed");
		else
			$display("keyframe_replay_window_cache_tb failed");
		$finish;
	end

endmodule
